// ===== src/swr_pkg.sv =====
// ----------------------------------------------------------------------------
// swr_pkg
// Shared types and constants for the streaming word replacement block.
// ----------------------------------------------------------------------------
package swr_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 64;
   localparam int WORD_MAX  = 8;
   localparam int LEN_W     = 4;
   localparam int IDX_W     = 3;
   localparam int ADDR_W    = 2;

   typedef enum logic [ADDR_W-1:0] {
      REG_SEARCH_WORD  = 2'd0,
      REG_SEARCH_LEN   = 2'd1,
      REG_REPL_WORD    = 2'd2,
      REG_REPL_LEN     = 2'd3
   } reg_addr_type;

   typedef struct packed {
      logic [WORD_W-1:0] bytes;
      logic [LEN_W-1:0]  count;
      logic              last;
      logic              marker;
   } swr_cmd_type;

endpackage

// ===== src/swr_front.sv =====
// ----------------------------------------------------------------------------
// swr_front
// Holds the configuration and the pending window, matches each incoming
// byte and emits one burst command per beat that yields output.
// ----------------------------------------------------------------------------
module swr_front
   import swr_pkg::*;
#(
   parameter int OLD_MAX = 8,
   parameter int NEW_MAX = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_end_of_text,
   input  logic                csr_we,
   input  logic [ADDR_W-1:0]   csr_addr,
   input  logic [WORD_W-1:0]   csr_wdata,
   input  logic                queue_full,
   output logic                cmd_push,
   output swr_cmd_type         cmd
);

   localparam int WIN_DEPTH = (OLD_MAX < WORD_MAX) ? OLD_MAX : WORD_MAX;
   localparam int REPL_CAP  = (NEW_MAX < WORD_MAX) ? NEW_MAX : WORD_MAX;

   logic [WORD_W-1:0] sw_ff, rw_ff;
   logic [LEN_W-1:0]  sl_ff, rl_ff;
   logic [BYTE_W-1:0] win_ff [WIN_DEPTH];
   logic [BYTE_W-1:0] win_in [WIN_DEPTH];
   logic [LEN_W-1:0]  cnt_ff, cnt_in;

   logic [BYTE_W-1:0] win_app [WIN_DEPTH];
   logic [WORD_W-1:0] win_bytes;
   logic [LEN_W-1:0]  len, rlen, cnt_c, cnt_app;
   logic              full, hit, accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (sl_ff == '0) begin
         len = LEN_W'(1);
      end else if (sl_ff > LEN_W'(WIN_DEPTH)) begin
         len = LEN_W'(WIN_DEPTH);
      end else begin
         len = sl_ff;
      end
      rlen = (rl_ff > LEN_W'(REPL_CAP)) ? LEN_W'(REPL_CAP) : rl_ff;

      cnt_c   = (cnt_ff >= len) ? len - LEN_W'(1) : cnt_ff;
      cnt_app = cnt_c + LEN_W'(1);
      full    = (cnt_app == len);

      win_bytes = '0;
      hit       = full;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_app[i] = (LEN_W'(i) == cnt_c) ? req_data_byte : win_ff[i];
         win_bytes[BYTE_W*i +: BYTE_W] = win_app[i];
         if (LEN_W'(i) < len && win_app[i] != sw_ff[BYTE_W*i +: BYTE_W]) begin
            hit = 1'b0;
         end
      end

      cmd.bytes  = win_bytes;
      cmd.count  = '0;
      cmd.last   = req_end_of_text;
      cmd.marker = 1'b0;
      if (hit) begin
         cmd.bytes = rw_ff;
         cmd.count = rlen;
         if (req_end_of_text && rlen == '0) begin
            cmd.bytes  = '0;
            cmd.count  = LEN_W'(1);
            cmd.marker = 1'b1;
         end
      end else if (full) begin
         cmd.count = req_end_of_text ? len : LEN_W'(1);
      end else if (req_end_of_text) begin
         cmd.count = cnt_app;
      end

      cmd_push = accept && (cmd.count != '0);

      win_in = win_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         win_in = win_app;
         if (hit || req_end_of_text) begin
            cnt_in = '0;
         end else if (full) begin
            cnt_in = len - LEN_W'(1);
            for (int i = 0; i + 1 < WIN_DEPTH; i++) begin
               win_in[i] = win_app[i+1];
            end
         end else begin
            cnt_in = cnt_app;
         end
      end
      if (csr_we && csr_addr == REG_SEARCH_LEN) begin
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (reset) begin
         cnt_ff <= '0;
         sw_ff  <= '0;
         sl_ff  <= LEN_W'(1);
         rw_ff  <= '0;
         rl_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (csr_we) begin
            case (csr_addr)
               REG_SEARCH_WORD: sw_ff <= csr_wdata;
               REG_SEARCH_LEN:  sl_ff <= csr_wdata[LEN_W-1:0];
               REG_REPL_WORD:   rw_ff <= csr_wdata;
               REG_REPL_LEN:    rl_ff <= csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== src/swr_fifo.sv =====
// ----------------------------------------------------------------------------
// swr_fifo
// Short command queue between the matcher and the output serializer.
// ----------------------------------------------------------------------------
module swr_fifo
   import swr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  swr_cmd_type push_data,
   input  logic        pop,
   output swr_cmd_type head,
   output logic        empty,
   output logic        full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   swr_cmd_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");
`endif

endmodule

// ===== src/swr_back.sv =====
// ----------------------------------------------------------------------------
// swr_back
// Serializes queued burst commands into one output beat per cycle while
// rsp_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module swr_back
   import swr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  swr_cmd_type         head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_final_item
);

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              bv_ff, fin_ff;
   logic              load, take, last_byte;

   assign load      = !valid_ff || rsp_ready;
   assign take      = load && !empty;
   assign last_byte = (LEN_W'(idx_ff) + LEN_W'(1) == head.count);
   assign pop       = take && last_byte;

   always_comb begin
      valid_in = load ? !empty : valid_ff;
      idx_in   = idx_ff;
      if (take) begin
         idx_in = last_byte ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= head.bytes[BYTE_W*idx_ff +: BYTE_W];
         bv_ff   <= !head.marker;
         fin_ff  <= head.last && last_byte;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_final_item = fin_ff;

`ifndef SYNTH
   a_head_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> head.count != '0)
      else $error("queued command without beats");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> LEN_W'(idx_ff) < head.count)
      else $error("serializer index past command length");
   a_marker_final: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !bv_ff) |-> fin_ff)
      else $error("bare marker beat not final");
`endif

endmodule

// ===== src/stream_word_replace.sv =====
// ----------------------------------------------------------------------------
// stream_word_replace
// Streaming find-and-replace over a byte stream with configurable words.
// ----------------------------------------------------------------------------
// Takes one input beat per cycle while the command queue has room. Each
// beat that completes a window yields one command of up to eight output
// beats (a match gives the replacement length, a miss one byte, the end of
// text the rest of the window), and the output stage sends one beat per
// cycle while rsp_ready is high, so sustained throughput is one byte per
// cycle for text without matches; a replacement longer than the search word
// costs extra output cycles that the FIFO_DEPTH-entry queue absorbs. Output
// is registered after the queue. Words must be written only while the block
// is idle (not enforced); writing the search length drops any pending bytes.
module stream_word_replace
   import swr_pkg::*;
#(
   parameter int OLD_MAX    = 8,
   parameter int NEW_MAX    = 8,
   parameter int FIFO_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_data_byte,
   input  logic                req_end_of_text,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_final_item,
   input  logic                csr_we,
   input  logic [ADDR_W-1:0]   csr_addr,
   input  logic [WORD_W-1:0]   csr_wdata
);

   swr_cmd_type cmd, head;
   logic        cmd_push, queue_full, queue_empty, pop;

   swr_front #(
      .OLD_MAX (OLD_MAX),
      .NEW_MAX (NEW_MAX)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .queue_full      (queue_full),
      .cmd_push        (cmd_push),
      .cmd             (cmd)
   );

   swr_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   swr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_final_item (rsp_final_item)
   );

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stream_word_replace.
// ----------------------------------------------------------------------------
// Text beats from a queue go through a valid/ready driver. A predictor keeps
// its own copy of the search window and the word registers and, for each
// accepted text beat, computes the output beats it causes. The monitor
// compares each output beat field by field with the oldest prediction.
// Directed texts come first: byte extremes, empty replacement markers,
// oversized and zero lengths, short texts, and a search length change in
// the middle of a text. Random phases with new word settings follow. Both
// sides idle at random, and one phase holds the output side off for a long
// stretch.
// ----------------------------------------------------------------------------
module tb;
   import swr_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_BEATS = 440;
   localparam int PHASE_BEATS  = 60;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_text;
   } text_beat_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              final_item;
   } text_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic                req_end_of_text = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_byte_valid;
   logic                rsp_final_item;
   logic                csr_we = 1'b0;
   logic [ADDR_W-1:0]   csr_addr = '0;
   logic [WORD_W-1:0]   csr_wdata = '0;

   // predictor copy of the word registers and the search window
   logic [WORD_W-1:0]   cfg_search_word = '0;
   logic [LEN_W-1:0]    cfg_search_len = LEN_W'(1);
   logic [WORD_W-1:0]   cfg_repl_word = '0;
   logic [LEN_W-1:0]    cfg_repl_len = '0;
   logic [BYTE_W-1:0]   window_bytes [WORD_MAX] = '{default: '0};
   int unsigned         window_count = 0;

   text_beat_type       text_beats_to_send [$];
   text_result_type     expected_out_beats [$];
   text_beat_type       next_beat;
   text_result_type     want_beat;

   int unsigned         send_gap = 0;
   int unsigned         recv_wait = 0;
   int unsigned         hold_left = 0;
   bit                  no_idle = 1'b0;
   bit                  stall_request = 1'b0;

   int unsigned         cycle_count = 0;
   int unsigned         error_count = 0;
   int unsigned         beats_accepted = 0;
   int unsigned         results_checked = 0;
   int unsigned         word_hits = 0;
   int unsigned         settings_count = 0;

   stream_word_replace u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_final_item  (rsp_final_item),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned active_search_len();
      int unsigned n;
      n = cfg_search_len;
      if (n == 0) n = 1;
      if (n > WORD_MAX) n = WORD_MAX;
      return n;
   endfunction

   function automatic int unsigned active_repl_len();
      int unsigned n;
      n = cfg_repl_len;
      if (n > WORD_MAX) n = WORD_MAX;
      return n;
   endfunction

   function automatic logic [BYTE_W-1:0] search_byte(input int unsigned k);
      return cfg_search_word[BYTE_W*k +: BYTE_W];
   endfunction

   function automatic text_result_type make_result(input logic [BYTE_W-1:0] b,
                                                   input logic valid);
      text_result_type r;
      r.out_byte = b;
      r.byte_valid = valid;
      r.final_item = 1'b0;
      return r;
   endfunction

   // next output beats caused by one accepted text beat
   task automatic replace_step(input logic [BYTE_W-1:0] b, input logic eot);
      int unsigned len;
      bit hit;
      text_result_type batch [$];
      text_result_type r;
      len = active_search_len();
      if (window_count >= len) window_count = len - 1;
      window_bytes[window_count] = b;
      window_count++;
      if (window_count == len) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++) begin
            if (window_bytes[i] != search_byte(i)) hit = 1'b0;
         end
         if (hit) begin
            word_hits++;
            for (int i = 0; i < active_repl_len(); i++) begin
               batch.push_back(make_result(cfg_repl_word[BYTE_W*i +: BYTE_W], 1'b1));
            end
            window_count = 0;
         end else begin
            batch.push_back(make_result(window_bytes[0], 1'b1));
            for (int i = 1; i < len; i++) window_bytes[i-1] = window_bytes[i];
            window_count--;
         end
      end
      if (eot) begin
         for (int i = 0; i < window_count; i++) begin
            batch.push_back(make_result(window_bytes[i], 1'b1));
         end
         window_count = 0;
         if (batch.size() == 0) batch.push_back(make_result('0, 1'b0));
         r = batch.pop_back();
         r.final_item = 1'b1;
         batch.push_back(r);
      end
      foreach (batch[i]) expected_out_beats.push_back(batch[i]);
   endtask

   task automatic write_reg(input reg_addr_type addr, input logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      case (addr)
         REG_SEARCH_WORD: cfg_search_word = value;
         REG_SEARCH_LEN: begin
            cfg_search_len = value[LEN_W-1:0];
            window_bytes = '{default: '0};
            window_count = 0;
         end
         REG_REPL_WORD: cfg_repl_word = value;
         REG_REPL_LEN: cfg_repl_len = value[LEN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_words(input logic [WORD_W-1:0] sw, input logic [LEN_W-1:0] sl,
                                input logic [WORD_W-1:0] rw, input logic [LEN_W-1:0] rl);
      write_reg(REG_SEARCH_WORD, sw);
      write_reg(REG_SEARCH_LEN, WORD_W'(sl));
      write_reg(REG_REPL_WORD, rw);
      write_reg(REG_REPL_LEN, WORD_W'(rl));
      settings_count++;
      @(negedge clock);
   endtask

   task automatic queue_beat(input logic [BYTE_W-1:0] b, input logic eot);
      text_beat_type t;
      t.data_byte = b;
      t.end_of_text = eot;
      text_beats_to_send.push_back(t);
   endtask

   task automatic queue_string(input string s, input bit ends);
      for (int i = 0; i < s.len(); i++) queue_beat(s[i], ends && (i == s.len() - 1));
   endtask

   // mostly whole or partial search words, some stray bytes
   task automatic queue_random_text(output int unsigned n);
      int unsigned slen;
      int unsigned cut;
      logic [BYTE_W-1:0] txt [$];
      slen = active_search_len();
      n = $urandom_range(1, 16);
      while (txt.size() < n) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               for (int k = 0; k < slen; k++) txt.push_back(search_byte(k));
            end
            4, 5: begin
               cut = $urandom_range(1, slen);
               for (int k = 0; k < cut; k++) txt.push_back(search_byte(k));
            end
            6, 7: txt.push_back(search_byte($urandom_range(0, slen - 1)));
            default: txt.push_back(BYTE_W'($urandom_range(0, 255)));
         endcase
      end
      for (int k = 0; k < n; k++) queue_beat(txt[k], k == n - 1);
   endtask

   task automatic wait_drained(input int unsigned extra);
      do @(negedge clock);
      while (text_beats_to_send.size() != 0 || req_valid || expected_out_beats.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            replace_step(req_data_byte, req_end_of_text);
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (text_beats_to_send.size() > 0) begin
               next_beat = text_beats_to_send.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_beat.data_byte;
               req_end_of_text <= next_beat.end_of_text;
               send_gap = no_idle ? 0 : $urandom_range(0, 5);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_out_beats.size() == 0) begin
               $error("unexpected beat: out_byte %0h byte_valid %0b final_item %0b",
                      rsp_out_byte, rsp_byte_valid, rsp_final_item);
               error_count++;
            end else begin
               want_beat = expected_out_beats.pop_front();
               results_checked++;
               if (rsp_out_byte !== want_beat.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want_beat.out_byte, rsp_out_byte);
                  error_count++;
               end
               if (rsp_byte_valid !== want_beat.byte_valid) begin
                  $error("byte_valid: expected %0b, got %0b",
                         want_beat.byte_valid, rsp_byte_valid);
                  error_count++;
               end
               if (rsp_final_item !== want_beat.final_item) begin
                  $error("final_item: expected %0b, got %0b",
                         want_beat.final_item, rsp_final_item);
                  error_count++;
               end
            end
            recv_wait = no_idle ? 0 : $urandom_range(0, 5);
         end
         if (stall_request) begin
            hold_left = STALL_CYCLES;
            stall_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected",
                  cycle_count, expected_out_beats.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned random_beats;
      int unsigned phase_beats;
      int unsigned text_len;
      int unsigned phase;
      logic [WORD_W-1:0] sw;
      logic [LEN_W-1:0] sl;
      logic [LEN_W-1:0] rl;

      random_beats = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset words: a zero byte is replaced by nothing, giving a bare marker
      queue_beat(8'h00, 1'b1);
      queue_beat(8'hff, 1'b1);
      wait_drained(DRAIN_CYCLES);

      program_words(64'h6261, 4'd2, 64'h5a5958, 4'd3);
      queue_string("xabya", 1'b1);
      queue_string("a", 1'b1);
      wait_drained(DRAIN_CYCLES);

      // zero search length acts as one, oversized replacement saturates
      program_words(64'h41, 4'd0, 64'h8899aabbccddeeff, 4'd15);
      queue_string("A", 1'b1);
      queue_string("BA", 1'b1);
      wait_drained(DRAIN_CYCLES);

      program_words(64'hffff_ffff_ffff_ffff, 4'd15, 64'h0, 4'd8);
      for (int i = 0; i < 8; i++) queue_beat(8'hff, i == 7);
      wait_drained(DRAIN_CYCLES);

      // search length rewritten mid-text drops the pending bytes
      program_words(64'h636261, 4'd3, 64'h21, 4'd1);
      queue_string("ab", 1'b0);
      wait_drained(DRAIN_CYCLES);
      write_reg(REG_SEARCH_LEN, 64'd3);
      @(negedge clock);
      queue_string("c", 1'b1);
      wait_drained(DRAIN_CYCLES);

      for (phase = 0; random_beats < RANDOM_BEATS; phase++) begin
         no_idle = (phase % 3 == 1) || (phase == 2);
         case (phase)
            0: begin sl = 4'd0;  rl = 4'd15; end
            1: begin sl = 4'd15; rl = 4'd0;  end
            2: begin sl = 4'd8;  rl = 4'd8;  end
            3: begin sl = 4'd1;  rl = 4'd0;  end
            default: begin
               sl = LEN_W'($urandom_range(1, 8));
               rl = LEN_W'($urandom_range(0, 9));
            end
         endcase
         if (phase % 2 == 1) begin
            sw = {$urandom, $urandom};
         end else begin
            for (int k = 0; k < WORD_MAX; k++) begin
               sw[BYTE_W*k +: BYTE_W] = BYTE_W'(8'h61 + $urandom_range(0, 1));
            end
         end
         program_words(sw, sl, {$urandom, $urandom}, rl);
         phase_beats = 0;
         while (phase_beats < PHASE_BEATS) begin
            queue_random_text(text_len);
            phase_beats += text_len;
            // sender waits for every result before the next text
            if (phase == 5) wait_drained(0);
         end
         random_beats += phase_beats;
         if (phase == 2) stall_request = 1'b1;
         wait_drained(DRAIN_CYCLES);
      end

      $display("covered %0d text beats in, %0d output beats checked, %0d word hits",
               beats_accepted, results_checked, word_hits);
      $display("over %0d word settings incl zero and oversized lengths, one long output stall",
               settings_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
